// ===== rtl/core/pdd_pkg.sv =====
// pdd_pkg: types and constants for the packed date decoder.
// Used by every file under rtl/core; depends on nothing.
package pdd_pkg;

   // Transfer payloads
   typedef struct packed {
      logic [7:0]  year_byte;
      logic [15:0] day_number;
   } req_type;

   typedef struct packed {
      logic        date_empty;
      logic        date_invalid;
      logic [11:0] year_value;
      logic [3:0]  month_index;
      logic [15:0] day_value;
   } rsp_type;

   // Stage 1 -> stage 2
   typedef struct packed {
      logic        calendar;
      logic        empty;
      logic [8:0]  year_sum;
      logic [15:0] day_number;
   } s1_type;

   // Stage 2 -> stage 3
   typedef struct packed {
      logic        calendar;
      logic        empty;
      logic        in_range;
      logic [11:0] year;
      logic [8:0]  day_from_march;
      logic [15:0] day_number;
   } s2_type;

   // Configuration register indexes
   localparam logic CSR_YEAR_OFFSET   = 1'b0;
   localparam logic CSR_CALENDAR_MODE = 1'b1;

   localparam logic [11:0] BASE_YEAR      = 12'd1900;
   localparam logic [8:0]  YEAR_DAYS      = 9'd365;
   localparam logic [8:0]  JANFEB_DAYS    = 9'd59;
   localparam logic [8:0]  MARFEB_SHIFT   = YEAR_DAYS - JANFEB_DAYS;
   localparam logic [8:0]  CYCLE_DAYS     = 9'd153;
   localparam logic [8:0]  TWO_CYCLE_DAYS = 9'd306;
   localparam logic [7:0]  PAIR_DAYS      = 8'd61;
   localparam logic [7:0]  TWO_PAIR_DAYS  = 8'd122;
   localparam logic [5:0]  LONG_MONTH     = 6'd31;
   localparam logic [3:0]  NO_MONTH       = 4'd12;
   localparam logic [3:0]  MONTHS_TO_JAN  = 4'd10;
   localparam logic [3:0]  MAR_INDEX      = 4'd2;

   // Year sums (year - 1900) of century years that are not leap years
   localparam logic [8:0] SUM_Y1900 = 9'd0;
   localparam logic [8:0] SUM_Y2100 = 9'd200;
   localparam logic [8:0] SUM_Y2200 = 9'd300;
   localparam logic [8:0] SUM_Y2300 = 9'd400;

   localparam logic [8:0] HUNDRED   = 9'd100;
   localparam logic [8:0] HUNDRED_2 = 9'd200;
   localparam logic [8:0] HUNDRED_3 = 9'd300;
   localparam logic [8:0] HUNDRED_4 = 9'd400;
   localparam logic [8:0] HUNDRED_5 = 9'd500;

endpackage

// ===== rtl/core/pdd_year.sv =====
// pdd_year: stage 1, adds the year offset and flags empty dates.
// Depends on pdd_pkg.
module pdd_year (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  pdd_pkg::req_type in_data,
   input  logic [7:0]      year_offset,
   input  logic            calendar_mode,
   output logic            s1_valid,
   output pdd_pkg::s1_type s1_data
);

   logic            valid_ff;
   pdd_pkg::s1_type data_ff, data_in;

   always_comb begin
      data_in.calendar   = calendar_mode;
      data_in.empty      = (in_data.year_byte == 8'd0) && (in_data.day_number[15:8] == 8'd0);
      data_in.year_sum   = {1'b0, in_data.year_byte} + {1'b0, year_offset};
      data_in.day_number = in_data.day_number;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

// ===== rtl/core/pdd_range.sv =====
// pdd_range: stage 2, leap year, day range check, year output and
// day count from 1 March. Depends on pdd_pkg.
module pdd_range (
   input  logic            clock,
   input  logic            reset,
   input  logic            s1_valid,
   input  pdd_pkg::s1_type s1_data,
   output logic            s2_valid,
   output pdd_pkg::s2_type s2_data
);

   logic            valid_ff;
   pdd_pkg::s2_type data_ff, data_in;
   logic            leap;
   logic [8:0]      last_day;
   logic [8:0]      janfeb_end;
   logic [8:0]      ord;
   logic [8:0]      yy;

   always_comb begin
      leap = (s1_data.year_sum[1:0] == 2'b00)
          && (s1_data.year_sum != pdd_pkg::SUM_Y1900)
          && (s1_data.year_sum != pdd_pkg::SUM_Y2100)
          && (s1_data.year_sum != pdd_pkg::SUM_Y2200)
          && (s1_data.year_sum != pdd_pkg::SUM_Y2300);
      last_day   = pdd_pkg::YEAR_DAYS + {8'd0, leap};
      janfeb_end = pdd_pkg::JANFEB_DAYS + {8'd0, leap};
      ord        = s1_data.day_number[8:0];

      // two-digit year: sum is at most 510
      if (s1_data.year_sum >= pdd_pkg::HUNDRED_5) begin
         yy = s1_data.year_sum - pdd_pkg::HUNDRED_5;
      end else if (s1_data.year_sum >= pdd_pkg::HUNDRED_4) begin
         yy = s1_data.year_sum - pdd_pkg::HUNDRED_4;
      end else if (s1_data.year_sum >= pdd_pkg::HUNDRED_3) begin
         yy = s1_data.year_sum - pdd_pkg::HUNDRED_3;
      end else if (s1_data.year_sum >= pdd_pkg::HUNDRED_2) begin
         yy = s1_data.year_sum - pdd_pkg::HUNDRED_2;
      end else if (s1_data.year_sum >= pdd_pkg::HUNDRED) begin
         yy = s1_data.year_sum - pdd_pkg::HUNDRED;
      end else begin
         yy = s1_data.year_sum;
      end

      data_in.calendar   = s1_data.calendar;
      data_in.empty      = s1_data.empty;
      data_in.day_number = s1_data.day_number;
      data_in.in_range   = (s1_data.day_number != 16'd0)
                        && (s1_data.day_number <= {7'd0, last_day});
      if (s1_data.calendar) begin
         data_in.year = pdd_pkg::BASE_YEAR + {3'd0, s1_data.year_sum};
      end else begin
         data_in.year = {3'd0, yy};
      end
      // January and February count after December
      if (ord <= janfeb_end) begin
         data_in.day_from_march = ord - 9'd1 + pdd_pkg::MARFEB_SHIFT;
      end else begin
         data_in.day_from_march = ord - 9'd1 - janfeb_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign s2_valid = valid_ff;
   assign s2_data  = data_ff;

endmodule

// ===== rtl/core/pdd_month.sv =====
// pdd_month: stage 3, splits the March-based day count into month and
// day and drives the result register. Depends on pdd_pkg.
module pdd_month (
   input  logic             clock,
   input  logic             reset,
   input  logic             s2_valid,
   input  pdd_pkg::s2_type  s2_data,
   output logic             rsp_valid,
   output pdd_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   pdd_pkg::rsp_type data_ff, data_in;
   logic [7:0]       r_cycle;
   logic [5:0]       r_pair;
   logic [4:0]       r_day;
   logic [3:0]       m_cycle, m_pair, m_mar;
   logic [3:0]       month;

   always_comb begin
      // 153-day cycles of five months; January and February sit in the third
      if (s2_data.day_from_march >= pdd_pkg::TWO_CYCLE_DAYS) begin
         r_cycle = 8'(s2_data.day_from_march - pdd_pkg::TWO_CYCLE_DAYS);
         m_cycle = 4'd10;
      end else if (s2_data.day_from_march >= pdd_pkg::CYCLE_DAYS) begin
         r_cycle = 8'(s2_data.day_from_march - pdd_pkg::CYCLE_DAYS);
         m_cycle = 4'd5;
      end else begin
         r_cycle = s2_data.day_from_march[7:0];
         m_cycle = 4'd0;
      end
      // 61-day month pairs
      if (r_cycle >= pdd_pkg::TWO_PAIR_DAYS) begin
         r_pair = 6'(r_cycle - pdd_pkg::TWO_PAIR_DAYS);
         m_pair = m_cycle + 4'd4;
      end else if (r_cycle >= pdd_pkg::PAIR_DAYS) begin
         r_pair = 6'(r_cycle - pdd_pkg::PAIR_DAYS);
         m_pair = m_cycle + 4'd2;
      end else begin
         r_pair = r_cycle[5:0];
         m_pair = m_cycle;
      end
      if (r_pair >= pdd_pkg::LONG_MONTH) begin
         r_day = 5'(r_pair - pdd_pkg::LONG_MONTH);
         m_mar = m_pair + 4'd1;
      end else begin
         r_day = r_pair[4:0];
         m_mar = m_pair;
      end
      month = (m_mar >= pdd_pkg::MONTHS_TO_JAN) ? (m_mar - pdd_pkg::MONTHS_TO_JAN)
                                                : (m_mar + pdd_pkg::MAR_INDEX);

      data_in.date_empty   = s2_data.empty;
      data_in.date_invalid = s2_data.calendar && !s2_data.in_range;
      data_in.year_value   = s2_data.year;
      if (s2_data.calendar && s2_data.in_range) begin
         data_in.month_index = month;
         data_in.day_value   = {11'd0, r_day} + 16'd1;
      end else begin
         data_in.month_index = pdd_pkg::NO_MONTH;
         data_in.day_value   = s2_data.day_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/core/packed_date_decoder.sv =====
// packed_date_decoder: three-stage pipeline that decodes a stored date.
// Path: a transfer is registered in stage 1, then stage 2, then the stage 3
// result register, which drives the rsp_valid strobe.
// Throughput: one transfer per cycle; busy is low except during reset,
// and the receiver cannot stall, so nothing ever backs up.
// Reset (synchronous, high): clears pipeline valid bits, year_offset=0,
// calendar_mode=0. Depends on pdd_pkg, pdd_year, pdd_range, pdd_month.
module packed_date_decoder (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             start,
   output logic             busy,
   input  pdd_pkg::req_type req_data,
   // result side: one-cycle strobe
   output logic             rsp_valid,
   output pdd_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   logic            accept;
   logic [7:0]      year_offset_ff;
   logic            calendar_mode_ff;
   logic            s1_valid, s2_valid;
   pdd_pkg::s1_type s1_data;
   pdd_pkg::s2_type s2_data;

   // No stall path: only reset holds off a transfer
   assign busy   = reset;
   assign accept = start && !busy;

   // Config registers; the user must write them only while the pipeline is empty (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         year_offset_ff   <= 8'd0;
         calendar_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            pdd_pkg::CSR_YEAR_OFFSET:   year_offset_ff   <= csr_wdata;
            pdd_pkg::CSR_CALENDAR_MODE: calendar_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage 1: year sum, empty flag
   pdd_year u_year (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_data       (req_data),
      .year_offset   (year_offset_ff),
      .calendar_mode (calendar_mode_ff),
      .s1_valid      (s1_valid),
      .s1_data       (s1_data)
   );

   // Stage 2: leap year, range check, output year, March-based day
   pdd_range u_range (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s2_valid (s2_valid),
      .s2_data  (s2_data)
   );

   // Stage 3: month/day split, result register
   pdd_month u_month (
      .clock     (clock),
      .reset     (reset),
      .s2_valid  (s2_valid),
      .s2_data   (s2_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Every transfer comes out of the pipeline as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("transfer lost in pipeline");

   // No result without an earlier transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without transfer");

   // An invalid date never carries a month
   a_invalid_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_invalid) |-> (rsp_data.month_index == pdd_pkg::NO_MONTH))
      else $error("invalid date with month");

   // A decoded month carries a day of month 1..31
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.month_index != pdd_pkg::NO_MONTH))
         |-> ((rsp_data.day_value >= 16'd1) && (rsp_data.day_value <= 16'd31)
              && (rsp_data.month_index < pdd_pkg::NO_MONTH)))
      else $error("day of month out of range");

endmodule
